/* src/depth_lut_remap_top_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the depth remap block.
// Each macro checks a property on the rising edge of clock, masked by reset.
// Defining ASSERT_OFF compiles every check away.
// ----------------------------------------------------------------------------
`ifndef DEPTH_LUT_REMAP_TOP_MACROS_SVH
`define DEPTH_LUT_REMAP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
// Condition that must hold in every cycle.
`define DLR_ASSERT(lbl, cond, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);
// Implication from an antecedent to a consequent sequence.
`define DLR_ASSERT_IMPL(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> cons) else $error(msg);
`else
`define DLR_ASSERT(lbl, cond, msg)
`define DLR_ASSERT_IMPL(lbl, ante, cons, msg)
`endif

`endif

/* src/dlr_pkg.sv */
// ----------------------------------------------------------------------------
// dlr_pkg
// Shared types and codes of the depth remap block.
// ----------------------------------------------------------------------------
`default_nettype none

package dlr_pkg;

   localparam int PIXEL_W       = 16;
   localparam int COORD_W       = 10;
   localparam int WEIGHT_W      = 17;
   localparam int INDEX_W       = 20;
   localparam int DIM_W         = 11;
   localparam int RATIO_W       = 16;
   localparam int RATIO_FRAC_BITS = 16;
   localparam int PROD_W        = PIXEL_W + WEIGHT_W;
   localparam int ACC_W         = PROD_W + 2;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   // Request kinds.
   localparam logic REQ_LOAD  = 1'b0;
   localparam logic REQ_REMAP = 1'b1;

   // Interpolation modes; any code above bilinear enables the depth checks.
   localparam logic [1:0] MODE_NEAREST  = 2'd0;
   localparam logic [1:0] MODE_BILINEAR = 2'd1;
   localparam logic [1:0] MODE_DEPTH    = 2'd2;

   // Result status codes.
   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_INVALID = 2'd1;
   localparam logic [1:0] STATUS_ZERO    = 2'd2;
   localparam logic [1:0] STATUS_DISCONT = 2'd3;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_INTERP_MODE  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKIP_RATIO   = 2'd3;

   // Register reset values.
   localparam logic [1:0]         RESET_MODE   = MODE_NEAREST;
   localparam logic [DIM_W-1:0]   RESET_WIDTH  = 11'd1024;
   localparam logic [DIM_W-1:0]   RESET_HEIGHT = 11'd1024;
   localparam logic [RATIO_W-1:0] RESET_RATIO  = 16'd3076;

   typedef logic [3:0][WEIGHT_W-1:0] weight_set_type;
   typedef logic [3:0][PIXEL_W-1:0]  pixel_set_type;

   // Control that travels with a remap request; in_frame bit order is
   // upper-left, upper-right, lower-left, lower-right.
   typedef struct packed {
      logic       valid;
      logic       entry_valid;
      logic [3:0] in_frame;
   } stage_ctrl_type;

endpackage

`default_nettype wire

/* src/dlr_ram.sv */
// ----------------------------------------------------------------------------
// dlr_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/dlr_addr.sv */
// ----------------------------------------------------------------------------
// dlr_addr
// Neighbor address generation: bounds checks, row offset and four addresses.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_addr #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  wire logic                                         clock,
   input  wire logic                                         reset,
   input  wire logic                                         remap_valid,
   input  wire logic [dlr_pkg::COORD_W-1:0]                  src_x,
   input  wire logic [dlr_pkg::COORD_W-1:0]                  src_y,
   input  wire logic                                         entry_valid,
   input  wire dlr_pkg::weight_set_type                      weights,
   input  wire logic [dlr_pkg::DIM_W-1:0]                    frame_width,
   input  wire logic [dlr_pkg::DIM_W-1:0]                    frame_height,
   output logic                                              rd_en,
   output logic [3:0][$clog2(MAX_WIDTH*MAX_HEIGHT)-1:0]      rd_addr,
   output dlr_pkg::stage_ctrl_type                           ctrl_out,
   output dlr_pkg::weight_set_type                           weights_out
);

   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int RW = dlr_pkg::COORD_W + WW;
   localparam int SW = RW + 2;
   localparam int AW = $clog2(MAX_WIDTH * MAX_HEIGHT);

   logic [WW-1:0] w_eff;
   logic [HW-1:0] h_eff;
   logic [3:0]    in_frame;

   dlr_pkg::stage_ctrl_type a2_ctrl_ff, a2_ctrl_in;
   dlr_pkg::weight_set_type a2_weights_ff;
   logic [RW-1:0]                a2_row_ff, a2_row_in;
   logic [WW-1:0]                a2_w_ff;
   logic [dlr_pkg::COORD_W-1:0]  a2_x_ff;
   logic [SW-1:0]                base;

   dlr_pkg::stage_ctrl_type a3_ctrl_ff;
   dlr_pkg::weight_set_type a3_weights_ff;

   // Geometry is clamped to the store's maximum frame size.
   always_comb begin
      w_eff = (32'(frame_width) > 32'(MAX_WIDTH))  ? WW'(MAX_WIDTH)  : WW'(frame_width);
      h_eff = (32'(frame_height) > 32'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(frame_height);
      in_frame[0] = (32'(src_x) < 32'(w_eff)) && (32'(src_y) < 32'(h_eff));
      in_frame[1] = (32'(src_x) + 32'd1 < 32'(w_eff)) && (32'(src_y) < 32'(h_eff));
      in_frame[2] = (32'(src_x) < 32'(w_eff)) && (32'(src_y) + 32'd1 < 32'(h_eff));
      in_frame[3] = (32'(src_x) + 32'd1 < 32'(w_eff)) && (32'(src_y) + 32'd1 < 32'(h_eff));
      a2_row_in = RW'(src_y) * RW'(w_eff);
      a2_ctrl_in.valid       = remap_valid;
      a2_ctrl_in.entry_valid = entry_valid;
      a2_ctrl_in.in_frame    = in_frame;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a2_ctrl_ff.valid <= 1'b0;
         a3_ctrl_ff.valid <= 1'b0;
      end else begin
         a2_ctrl_ff.valid <= a2_ctrl_in.valid;
         a3_ctrl_ff.valid <= a2_ctrl_ff.valid;
      end
      a2_ctrl_ff.entry_valid <= a2_ctrl_in.entry_valid;
      a2_ctrl_ff.in_frame    <= a2_ctrl_in.in_frame;
      a2_weights_ff          <= weights;
      a2_row_ff              <= a2_row_in;
      a2_w_ff                <= w_eff;
      a2_x_ff                <= src_x;
      a3_ctrl_ff.entry_valid <= a2_ctrl_ff.entry_valid;
      a3_ctrl_ff.in_frame    <= a2_ctrl_ff.in_frame;
      a3_weights_ff          <= a2_weights_ff;
   end

   // Out-of-frame addresses may wrap; their data is masked downstream.
   always_comb begin
      base       = SW'(a2_row_ff) + SW'(a2_x_ff);
      rd_addr[0] = AW'(base);
      rd_addr[1] = AW'(base + SW'(1));
      rd_addr[2] = AW'(base + SW'(a2_w_ff));
      rd_addr[3] = AW'(base + SW'(a2_w_ff) + SW'(1));
   end

   assign rd_en       = a2_ctrl_ff.valid;
   assign ctrl_out    = a3_ctrl_ff;
   assign weights_out = a3_weights_ff;

   `include "depth_lut_remap_top_macros.svh"

   `DLR_ASSERT_IMPL(a_addr_stage_advances, a2_ctrl_ff.valid, ##1 ctrl_out.valid, "address stage lost a request")

endmodule

`default_nettype wire

/* src/dlr_interp.sv */
// ----------------------------------------------------------------------------
// dlr_interp
// Neighbor masking, depth checks, weighted sum, rounding and result select.
// ----------------------------------------------------------------------------
`default_nettype none

module dlr_interp #(
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire dlr_pkg::stage_ctrl_type        ctrl_in,
   input  wire dlr_pkg::weight_set_type        weights,
   input  wire dlr_pkg::pixel_set_type         nbr_data,
   input  wire logic [1:0]                     interp_mode,
   input  wire logic [dlr_pkg::RATIO_W-1:0]    skip_ratio,
   output logic                                rsp_valid,
   output logic [dlr_pkg::PIXEL_W-1:0]         rsp_depth_out,
   output logic [1:0]                          rsp_out_status
);

   localparam int PW = dlr_pkg::PIXEL_W;
   localparam int AC = dlr_pkg::ACC_W;
   localparam int RP = dlr_pkg::RATIO_W + dlr_pkg::PIXEL_W;
   localparam logic [AC-1:0] ROUND_HALF = AC'(1) << (WEIGHT_FRAC_BITS - 1);
   localparam logic [AC-1:0] SAT_MAX    = AC'({PW{1'b1}});

   dlr_pkg::pixel_set_type                 nbr;
   logic [PW-1:0]                          mn, mx;
   logic [3:0][dlr_pkg::PROD_W-1:0]        p_prod_in, p_prod_ff;
   logic                                   p_valid_ff, p_ev_ff;
   logic [PW-1:0]                          p_mn_ff, p_mx_ff, p_n0_ff;

   logic                                   q_valid_ff, q_ev_ff, q_zero_ff;
   logic [AC-1:0]                          q_acc_in, q_acc_ff;
   logic [RP-1:0]                          q_ratio_ff;
   logic [PW-1:0]                          q_spread_ff, q_n0_ff;

   logic                                   check_on, discont;
   logic [AC-1:0]                          shifted;
   logic [PW-1:0]                          depth_in;
   logic [1:0]                             status_in;
   logic                                   rsp_valid_ff;
   logic [PW-1:0]                          rsp_depth_ff;
   logic [1:0]                             rsp_status_ff;

   // Neighbors outside the frame read as zero.
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         nbr[i]       = ctrl_in.in_frame[i] ? nbr_data[i] : '0;
         p_prod_in[i] = dlr_pkg::PROD_W'(nbr[i]) * dlr_pkg::PROD_W'(weights[i]);
      end
      mn = nbr[0];
      mx = nbr[0];
      for (int i = 1; i < 4; i++) begin
         if (nbr[i] < mn) begin
            mn = nbr[i];
         end
         if (nbr[i] > mx) begin
            mx = nbr[i];
         end
      end
   end

   always_comb begin
      q_acc_in = AC'(p_prod_ff[0]) + AC'(p_prod_ff[1]) + AC'(p_prod_ff[2])
               + AC'(p_prod_ff[3]) + ROUND_HALF;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_valid_ff   <= 1'b0;
         q_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         p_valid_ff   <= ctrl_in.valid;
         q_valid_ff   <= p_valid_ff;
         rsp_valid_ff <= q_valid_ff;
      end
      p_ev_ff     <= ctrl_in.entry_valid;
      p_prod_ff   <= p_prod_in;
      p_mn_ff     <= mn;
      p_mx_ff     <= mx;
      p_n0_ff     <= nbr[0];
      q_ev_ff     <= p_ev_ff;
      q_zero_ff   <= (p_mn_ff == '0);
      q_acc_ff    <= q_acc_in;
      q_ratio_ff  <= RP'(skip_ratio) * RP'(p_mn_ff);
      q_spread_ff <= p_mx_ff - p_mn_ff;
      q_n0_ff     <= p_n0_ff;
      rsp_depth_ff  <= depth_in;
      rsp_status_ff <= status_in;
   end

   always_comb begin
      check_on = (interp_mode != dlr_pkg::MODE_NEAREST)
              && (interp_mode != dlr_pkg::MODE_BILINEAR);
      discont  = {q_spread_ff, {dlr_pkg::RATIO_FRAC_BITS{1'b0}}} > q_ratio_ff;
      shifted  = q_acc_ff >> WEIGHT_FRAC_BITS;
      depth_in  = '0;
      status_in = dlr_pkg::STATUS_OK;
      if (!q_ev_ff) begin
         status_in = dlr_pkg::STATUS_INVALID;
      end else if (interp_mode == dlr_pkg::MODE_NEAREST) begin
         depth_in = q_n0_ff;
      end else if (check_on && q_zero_ff) begin
         status_in = dlr_pkg::STATUS_ZERO;
      end else if (check_on && discont) begin
         status_in = dlr_pkg::STATUS_DISCONT;
      end else if (shifted > SAT_MAX) begin
         depth_in = {PW{1'b1}};
      end else begin
         depth_in = PW'(shifted);
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_depth_out  = rsp_depth_ff;
   assign rsp_out_status = rsp_status_ff;

   `include "depth_lut_remap_top_macros.svh"

   `DLR_ASSERT_IMPL(a_skip_gives_zero, rsp_valid_ff && rsp_status_ff != dlr_pkg::STATUS_OK, rsp_depth_ff == '0, "skipped result carries nonzero depth")
   `DLR_ASSERT_IMPL(a_depth_codes_need_checks, rsp_valid_ff && (rsp_status_ff == dlr_pkg::STATUS_ZERO || rsp_status_ff == dlr_pkg::STATUS_DISCONT), check_on, "depth status without depth checks")

endmodule

`default_nettype wire

/* src/depth_lut_remap_top.sv */
// ----------------------------------------------------------------------------
// depth_lut_remap_top
// A result strobe rises after the input, address and interpolation stages.
// Throughput: one request per cycle; busy stays low and loads cost one slot.
// The rate is set by four replicated frame store copies, one per neighbor read.
// Reset empties the pipeline and presets the registers; the store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module depth_lut_remap_top #(
   parameter int MAX_WIDTH        = 1024,
   parameter int MAX_HEIGHT       = 1024,
   parameter int WEIGHT_FRAC_BITS = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // Request channel.
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic                              req_type,
   input  wire logic [dlr_pkg::INDEX_W-1:0]       req_pixel_index,
   input  wire logic [dlr_pkg::PIXEL_W-1:0]       req_pixel_value,
   input  wire logic [dlr_pkg::COORD_W-1:0]       req_src_x,
   input  wire logic [dlr_pkg::COORD_W-1:0]       req_src_y,
   input  wire logic                              req_entry_valid,
   input  wire logic [dlr_pkg::WEIGHT_W-1:0]      req_weight_ul,
   input  wire logic [dlr_pkg::WEIGHT_W-1:0]      req_weight_ur,
   input  wire logic [dlr_pkg::WEIGHT_W-1:0]      req_weight_ll,
   input  wire logic [dlr_pkg::WEIGHT_W-1:0]      req_weight_lr,
   // Result channel.
   output logic                                   rsp_valid,
   output logic [dlr_pkg::PIXEL_W-1:0]            rsp_depth_out,
   output logic [1:0]                             rsp_out_status,
   // Configuration write port.
   input  wire logic                              csr_we,
   input  wire logic [dlr_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [dlr_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // The frame store holds the largest frame; a pixel address is row times
   // width plus column, with the width clamped to MAX_WIDTH.
   localparam int STORE_DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW          = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [1:0]                    mode_ff;
   logic [dlr_pkg::DIM_W-1:0]     width_ff;
   logic [dlr_pkg::DIM_W-1:0]     height_ff;
   logic [dlr_pkg::RATIO_W-1:0]   ratio_ff;

   // First stage: the accepted request, registered as it arrived.
   logic                          accept;
   logic                          s1_valid_ff;
   logic                          s1_type_ff;
   logic [dlr_pkg::INDEX_W-1:0]   s1_index_ff;
   logic [dlr_pkg::PIXEL_W-1:0]   s1_value_ff;
   logic [dlr_pkg::COORD_W-1:0]   s1_x_ff;
   logic [dlr_pkg::COORD_W-1:0]   s1_y_ff;
   logic                          s1_ev_ff;
   dlr_pkg::weight_set_type       s1_weights_ff;

   logic                          store_we;
   logic                          remap_valid;
   logic                          rd_en;
   logic [3:0][AW-1:0]            rd_addr;
   dlr_pkg::pixel_set_type        nbr_data;
   dlr_pkg::stage_ctrl_type       a3_ctrl;
   dlr_pkg::weight_set_type       a3_weights;

   // The pipeline never stalls and the receiver cannot push back, so a new
   // request is taken in every cycle.
   assign busy   = 1'b0;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= dlr_pkg::RESET_MODE;
         width_ff  <= dlr_pkg::RESET_WIDTH;
         height_ff <= dlr_pkg::RESET_HEIGHT;
         ratio_ff  <= dlr_pkg::RESET_RATIO;
      end else if (csr_we) begin
         unique case (csr_index)
            dlr_pkg::CSR_INTERP_MODE:  mode_ff   <= csr_wdata[1:0];
            dlr_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata[dlr_pkg::DIM_W-1:0];
            dlr_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata[dlr_pkg::DIM_W-1:0];
            dlr_pkg::CSR_SKIP_RATIO:   ratio_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
      s1_type_ff       <= req_type;
      s1_index_ff      <= req_pixel_index;
      s1_value_ff      <= req_pixel_value;
      s1_x_ff          <= req_src_x;
      s1_y_ff          <= req_src_y;
      s1_ev_ff         <= req_entry_valid;
      s1_weights_ff[0] <= req_weight_ul;
      s1_weights_ff[1] <= req_weight_ur;
      s1_weights_ff[2] <= req_weight_ll;
      s1_weights_ff[3] <= req_weight_lr;
   end

   // A load writes the store from the first-stage registers, while a remap
   // presents its read addresses only from the address-stage registers after
   // them, so a remap that follows a load directly already sees the new pixel.
   // Loads beyond the store are dropped.
   assign store_we    = s1_valid_ff && (s1_type_ff == dlr_pkg::REQ_LOAD)
                     && (32'(s1_index_ff) < 32'(STORE_DEPTH));
   assign remap_valid = s1_valid_ff && (s1_type_ff == dlr_pkg::REQ_REMAP);

   dlr_addr #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_addr (
      .clock        (clock),
      .reset        (reset),
      .remap_valid  (remap_valid),
      .src_x        (s1_x_ff),
      .src_y        (s1_y_ff),
      .entry_valid  (s1_ev_ff),
      .weights      (s1_weights_ff),
      .frame_width  (width_ff),
      .frame_height (height_ff),
      .rd_en        (rd_en),
      .rd_addr      (rd_addr),
      .ctrl_out     (a3_ctrl),
      .weights_out  (a3_weights)
   );

   // Four full copies of the frame store, written together, give each
   // neighbor a read port of its own in every cycle.
   for (genvar g = 0; g < 4; g++) begin : g_store
      dlr_ram #(
         .WIDTH (dlr_pkg::PIXEL_W),
         .DEPTH (STORE_DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (store_we),
         .wr_addr (AW'(s1_index_ff)),
         .wr_data (s1_value_ff),
         .rd_en   (rd_en),
         .rd_addr (rd_addr[g]),
         .rd_data (nbr_data[g])
      );
   end

   // Masking, depth checks, the weighted sum and the final select take
   // three more register stages.
   dlr_interp #(
      .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
   ) u_interp (
      .clock          (clock),
      .reset          (reset),
      .ctrl_in        (a3_ctrl),
      .weights        (a3_weights),
      .nbr_data       (nbr_data),
      .interp_mode    (mode_ff),
      .skip_ratio     (ratio_ff),
      .rsp_valid      (rsp_valid),
      .rsp_depth_out  (rsp_depth_out),
      .rsp_out_status (rsp_out_status)
   );

   `include "depth_lut_remap_top_macros.svh"

   `DLR_ASSERT_IMPL(a_remap_yields_result, remap_valid, ##5 rsp_valid, "remap request produced no result")
   `DLR_ASSERT_IMPL(a_load_yields_nothing, s1_valid_ff && s1_type_ff == dlr_pkg::REQ_LOAD, ##5 !rsp_valid, "load request produced a result")

endmodule

`default_nettype wire
